### hdl/sfr_pkg.sv
// Shared types, widths and register codes for the spectral frequency remap unit.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int DATA_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int ROW_W          = 3 * COEF_W;
  localparam int LAM_W          = 48;

  // matrix datapath
  localparam int PROD_W = COEF_W + DATA_WIDTH;
  localparam int SUM_W  = PROD_W + 2;

  // squared magnitude
  localparam int SQ_W    = 2 * DATA_WIDTH;
  localparam int SUMSQ_W = SQ_W + 1;
  localparam int CMP_W   = (SUMSQ_W > LAM_W) ? SUMSQ_W : LAM_W;

  // square root: two root bits per pipeline stage
  localparam int ROOT_W    = LAM_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int SQ_STAGES = ROOT_W / 2;
  localparam int ZW        = (ROOT_W > DATA_WIDTH) ? ROOT_W : DATA_WIDTH;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (ROW_W > LAM_W) ? ROW_W : LAM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_ROW_X  = 3'd1,
    REG_ROW_Y  = 3'd2,
    REG_OFF_X  = 3'd3,
    REG_OFF_Y  = 3'd4,
    REG_LAMBDA = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_MATRIX = 1'b0,
    MODE_SHIFT  = 1'b1
  } xform_mode_t;

  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(1) << COEF_FRAC_BITS;
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
  localparam logic [LAM_W-1:0] LAM_RST   = LAM_W'(1) << (LAM_W / 2);

  typedef struct packed {
    xform_mode_t                   mode;
    logic        [ROW_W-1:0]       row_x;
    logic        [ROW_W-1:0]       row_y;
    logic signed [DATA_WIDTH-1:0]  off_x;
    logic signed [DATA_WIDTH-1:0]  off_y;
    logic        [LAM_W-1:0]       lam;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] fx;
    logic signed [DATA_WIDTH-1:0] fy;
  } xy_t;

endpackage

`default_nettype wire

### hdl/sfr_xform.sv
// Transform front end: rounded matrix-row products or offset subtract, then saturate.
// Two register stages. Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_xform import sfr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfg_t                          cfg,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]  in_x,
  input  wire logic signed [DATA_WIDTH-1:0]  in_y,
  input  wire logic signed [DATA_WIDTH-1:0]  in_z,
  output      logic                          xf_valid,
  input  wire logic                          xf_ready,
  output      xy_t                           xf_word
);

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (COEF_FRAC_BITS - 1);

  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    lo = {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    if (v > hi) begin
      sat_data = hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      sat_data = lo[DATA_WIDTH-1:0];
    end else begin
      sat_data = v[DATA_WIDTH-1:0];
    end
  endfunction

  // stage A: products and differences
  logic                          va_r;
  xform_mode_t                   mode_a_r;
  logic signed [PROD_W-1:0]      prod_a_r [6];
  logic signed [DATA_WIDTH:0]    dx_a_r;
  logic signed [DATA_WIDTH:0]    dy_a_r;
  logic signed [PROD_W-1:0]      prod_nxt [6];
  logic signed [DATA_WIDTH:0]    dx_nxt;
  logic signed [DATA_WIDTH:0]    dy_nxt;
  logic signed [DATA_WIDTH-1:0]  vec [3];
  logic signed [COEF_W-1:0]      cx;
  logic signed [COEF_W-1:0]      cy;

  // stage B: rounded, saturated components
  logic                          vb_r;
  xy_t                           word_b_r;
  xy_t                           word_nxt;
  logic signed [SUM_W-1:0]       sum_x;
  logic signed [SUM_W-1:0]       sum_y;
  logic signed [SUM_W-1:0]       rnd_x;
  logic signed [SUM_W-1:0]       rnd_y;

  logic adv_a;
  logic adv_b;

  // a stage loads when it is empty or its content moves on
  assign adv_b    = !vb_r || xf_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    vec[0] = in_x;
    vec[1] = in_y;
    vec[2] = in_z;
    cx     = '0;
    cy     = '0;
    for (int j = 0; j < 3; j++) begin
      cx              = $signed(cfg.row_x[j*COEF_W +: COEF_W]);
      cy              = $signed(cfg.row_y[j*COEF_W +: COEF_W]);
      prod_nxt[j]     = PROD_W'(cx) * PROD_W'(vec[j]);
      prod_nxt[j + 3] = PROD_W'(cy) * PROD_W'(vec[j]);
    end
    dx_nxt = (DATA_WIDTH+1)'(in_x) - (DATA_WIDTH+1)'(cfg.off_x);
    dy_nxt = (DATA_WIDTH+1)'(in_y) - (DATA_WIDTH+1)'(cfg.off_y);
  end

  always_comb begin
    sum_x = SUM_W'(prod_a_r[0]) + SUM_W'(prod_a_r[1]) + SUM_W'(prod_a_r[2]) + RND;
    sum_y = SUM_W'(prod_a_r[3]) + SUM_W'(prod_a_r[4]) + SUM_W'(prod_a_r[5]) + RND;
    rnd_x = sum_x >>> COEF_FRAC_BITS;
    rnd_y = sum_y >>> COEF_FRAC_BITS;
    if (mode_a_r == MODE_SHIFT) begin
      word_nxt.fx = sat_data(SUM_W'(dx_a_r));
      word_nxt.fy = sat_data(SUM_W'(dy_a_r));
    end else begin
      word_nxt.fx = sat_data(rnd_x);
      word_nxt.fy = sat_data(rnd_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= in_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      mode_a_r <= cfg.mode;
      prod_a_r <= prod_nxt;
      dx_a_r   <= dx_nxt;
      dy_a_r   <= dy_nxt;
    end
    if (adv_b) begin
      word_b_r <= word_nxt;
    end
  end

  assign xf_valid = vb_r;
  assign xf_word  = word_b_r;

endmodule

`default_nettype wire

### hdl/sfr_mag.sv
// Squared magnitude, evanescent test and remaining squared frequency.
// Two register stages; drops evanescent words. Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_mag import sfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [LAM_W-1:0]  lam,
  input  wire logic              xf_valid,
  output      logic              xf_ready,
  input  wire xy_t               xf_word,
  output      logic              mg_valid,
  input  wire logic              mg_ready,
  output      xy_t               mg_word,
  output      logic [LAM_W-1:0]  mg_rad
);

  // stage C: squares
  logic                   vc_r;
  xy_t                    word_c_r;
  logic [SQ_W-1:0]        sqx_r;
  logic [SQ_W-1:0]        sqy_r;
  logic [DATA_WIDTH-1:0]  ax;
  logic [DATA_WIDTH-1:0]  ay;
  logic [SQ_W-1:0]        sqx_nxt;
  logic [SQ_W-1:0]        sqy_nxt;

  // stage D: remainder under 1/lambda^2
  logic                   vd_r;
  xy_t                    word_d_r;
  logic [LAM_W-1:0]       rad_r;
  logic [SUMSQ_W-1:0]     s_sum;
  logic                   keep;
  logic [CMP_W-1:0]       diff;
  logic [LAM_W-1:0]       rad_nxt;

  logic adv_c;
  logic adv_d;

  assign adv_d    = !vd_r || mg_ready;
  assign adv_c    = !vc_r || adv_d;
  assign xf_ready = adv_c;

  always_comb begin
    // the most negative value maps to its unsigned magnitude
    ax      = xf_word.fx[DATA_WIDTH-1] ? DATA_WIDTH'(-xf_word.fx) : DATA_WIDTH'(xf_word.fx);
    ay      = xf_word.fy[DATA_WIDTH-1] ? DATA_WIDTH'(-xf_word.fy) : DATA_WIDTH'(xf_word.fy);
    sqx_nxt = SQ_W'(ax) * SQ_W'(ax);
    sqy_nxt = SQ_W'(ay) * SQ_W'(ay);
  end

  always_comb begin
    s_sum   = SUMSQ_W'(sqx_r) + SUMSQ_W'(sqy_r);
    keep    = CMP_W'(s_sum) <= CMP_W'(lam);
    diff    = CMP_W'(lam) - CMP_W'(s_sum);
    rad_nxt = diff[LAM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_c) begin
        vc_r <= xf_valid;
      end
      if (adv_d) begin
        // drop evanescent words here
        vd_r <= vc_r && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      word_c_r <= xf_word;
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
    end
    if (adv_d) begin
      word_d_r <= word_c_r;
      rad_r    <= rad_nxt;
    end
  end

  assign mg_valid = vd_r;
  assign mg_word  = word_d_r;
  assign mg_rad   = rad_r;

endmodule

`default_nettype wire

### hdl/sfr_sqrt.sv
// Pipelined integer square root, two root bits per stage; last stage is the output register.
// Carries the transformed components alongside. Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_sqrt import sfr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          mg_valid,
  output      logic                          mg_ready,
  input  wire xy_t                           mg_word,
  input  wire logic [LAM_W-1:0]              mg_rad,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [DATA_WIDTH-1:0]  out_x,
  output      logic signed [DATA_WIDTH-1:0]  out_y,
  output      logic [DATA_WIDTH-1:0]         out_z
);

  localparam int TRIAL_W = REM_W + 1;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  function automatic sq_state_t sq_step(
    input sq_state_t  st,
    input logic [1:0] bits
  );
    logic [REM_W-1:0]   shifted;
    logic [TRIAL_W-1:0] trial;
    sq_state_t          res;
    shifted = {st.rem[REM_W-3:0], bits};
    trial   = {1'b0, shifted} - TRIAL_W'({st.root, 2'b01});
    if (!trial[TRIAL_W-1]) begin
      res.rem  = trial[REM_W-1:0];
      res.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = shifted;
      res.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    sq_step = res;
  endfunction

  logic              v_r    [SQ_STAGES];
  xy_t               word_r [SQ_STAGES];
  logic [LAM_W-1:0]  rad_r  [SQ_STAGES];
  sq_state_t         st_r   [SQ_STAGES];
  logic [LAM_W-1:0]  rad_nxt [SQ_STAGES];
  sq_state_t         st_nxt  [SQ_STAGES];
  logic              adv    [SQ_STAGES+1];
  logic [ZW-1:0]     root_ext;

  always_comb begin
    adv[SQ_STAGES] = !out_stall;
    for (int k = SQ_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k + 1];
    end
  end

  assign mg_ready = adv[0];

  always_comb begin
    sq_state_t  src;
    logic [LAM_W-1:0] rad_in;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        src.rem  = '0;
        src.root = '0;
        rad_in   = mg_rad;
      end else begin
        src    = st_r[k - 1];
        rad_in = rad_r[k - 1];
      end
      st_nxt[k]  = sq_step(sq_step(src, rad_in[LAM_W-1 -: 2]), rad_in[LAM_W-3 -: 2]);
      rad_nxt[k] = rad_in << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= (k == 0) ? mg_valid : v_r[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (adv[k]) begin
        word_r[k] <= (k == 0) ? mg_word : word_r[k - 1];
        rad_r[k]  <= rad_nxt[k];
        st_r[k]   <= st_nxt[k];
      end
    end
  end

  // clamp the root to the output width
  always_comb begin
    root_ext = ZW'(st_r[SQ_STAGES-1].root);
    if (root_ext > ZW'({DATA_WIDTH{1'b1}})) begin
      out_z = '1;
    end else begin
      out_z = root_ext[DATA_WIDTH-1:0];
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_x     = word_r[SQ_STAGES-1].fx;
  assign out_y     = word_r[SQ_STAGES-1].fy;

endmodule

`default_nettype wire

### hdl/spectral_frequency_remap_unit.sv
// Top level of the spectral frequency remap unit: configuration registers and pipeline.
// Depends on sfr_pkg, sfr_xform, sfr_mag and sfr_sqrt.
//
// Usage:
//   Input channel in_valid/in_stall carries one frequency word (in_x, in_y, in_z).
//   Result channel out_valid/out_stall carries (out_x, out_y, out_z); a word
//   moves when valid is high and stall is low on the same rising edge.
//   Configuration channel cfg_valid/cfg_ready writes cfg_data into the register
//   selected by cfg_index (mode, row x, row y, offset x, offset y, 1/lambda^2);
//   cfg_ready is always high and unknown indexes are ignored. Write only while idle.
// Timing:
//   Sixteen register stages: two transform stages, two magnitude stages and twelve
//   square-root stages, each resolving two root bits. out_valid is the last stage's valid.
//   One word per cycle is accepted sustained while out_stall stays low.
//   Evanescent words (squared magnitude above 1/lambda^2) leave no result.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
//   default registers: matrix mode, identity rows, zero offsets, 1/lambda^2 = 1.0.
// Stall: each stage holds while the stage after it is full and stalled; empty
//   stages keep filling, so in_stall rises only when the whole pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

module spectral_frequency_remap_unit import sfr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]  in_x,
  input  wire logic signed [DATA_WIDTH-1:0]  in_y,
  input  wire logic signed [DATA_WIDTH-1:0]  in_z,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [DATA_WIDTH-1:0]  out_x,
  output      logic signed [DATA_WIDTH-1:0]  out_y,
  output      logic [DATA_WIDTH-1:0]         out_z
);

  cfg_t              cfg_r;
  logic              in_ready;
  logic              xf_valid;
  logic              xf_ready;
  xy_t               xf_word;
  logic              mg_valid;
  logic              mg_ready;
  xy_t               mg_word;
  logic [LAM_W-1:0]  mg_rad;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_MATRIX;
      cfg_r.row_x <= ROW_X_RST;
      cfg_r.row_y <= ROW_Y_RST;
      cfg_r.off_x <= '0;
      cfg_r.off_y <= '0;
      cfg_r.lam   <= LAM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:   cfg_r.mode  <= xform_mode_t'(cfg_data[0]);
        REG_ROW_X:  cfg_r.row_x <= cfg_data[ROW_W-1:0];
        REG_ROW_Y:  cfg_r.row_y <= cfg_data[ROW_W-1:0];
        REG_OFF_X:  cfg_r.off_x <= cfg_data[DATA_WIDTH-1:0];
        REG_OFF_Y:  cfg_r.off_y <= cfg_data[DATA_WIDTH-1:0];
        REG_LAMBDA: cfg_r.lam   <= cfg_data[LAM_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  sfr_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_word  (xf_word)
  );

  sfr_mag u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .lam      (cfg_r.lam),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_word  (xf_word),
    .mg_valid (mg_valid),
    .mg_ready (mg_ready),
    .mg_word  (mg_word),
    .mg_rad   (mg_rad)
  );

  sfr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .mg_valid  (mg_valid),
    .mg_ready  (mg_ready),
    .mg_word   (mg_word),
    .mg_rad    (mg_rad),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

endmodule

`default_nettype wire

### tb/spectral_remap_checker.sv
// Watches the configuration, input and result channels of the spectral frequency remap unit,
// predicts every result word from its own copy of the registers and compares them in order.
// Depends on sfr_pkg for widths, register codes and the register struct.
`timescale 1ns / 1ps

module spectral_remap_checker import sfr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  input  logic signed [DATA_WIDTH-1:0] in_z,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [DATA_WIDTH-1:0] out_x,
  input  logic signed [DATA_WIDTH-1:0] out_y,
  input  logic [DATA_WIDTH-1:0]        out_z,
  output int                           mismatch_count,
  output int                           beams_pending
);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] fx;
    logic signed [DATA_WIDTH-1:0] fy;
    logic        [DATA_WIDTH-1:0] kz;
  } beam_t;

  cfg_t  regs;
  beam_t expected_beams[$];

  function automatic longint clamp_data(input longint v);
    longint hi;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Exact dot product, round half up to Q11.12, then clamp.
  function automatic longint row_dot(input logic [ROW_W-1:0] row, input longint x,
                                     input longint y, input longint z);
    longint cx, cy, cz, acc;
    cx  = $signed(row[COEF_W-1:0]);
    cy  = $signed(row[2*COEF_W-1:COEF_W]);
    cz  = $signed(row[3*COEF_W-1:2*COEF_W]);
    acc = cx * x + cy * y + cz * z + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    return clamp_data(acc >>> COEF_FRAC_BITS);
  endfunction

  // Returns 0 for an evanescent word, which leaves no result.
  function automatic bit remap_frequency(input logic signed [DATA_WIDTH-1:0] x,
                                         input logic signed [DATA_WIDTH-1:0] y,
                                         input logic signed [DATA_WIDTH-1:0] z,
                                         output beam_t beam);
    longint          fx, fy;
    longint unsigned sumsq, w, root, trial;
    if (regs.mode == MODE_MATRIX) begin
      fx = row_dot(regs.row_x, x, y, z);
      fy = row_dot(regs.row_y, x, y, z);
    end else begin
      fx = clamp_data(longint'(x) - longint'(regs.off_x));
      fy = clamp_data(longint'(y) - longint'(regs.off_y));
    end
    beam  = '0;
    sumsq = fx * fx + fy * fy;
    if (sumsq > regs.lam) return 1'b0;
    w    = regs.lam - sumsq;
    root = 0;
    for (int b = DATA_WIDTH - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= w) root = trial;
    end
    beam.fx = fx[DATA_WIDTH-1:0];
    beam.fy = fy[DATA_WIDTH-1:0];
    beam.kz = root[DATA_WIDTH-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    beam_t predicted, oldest, seen;
    if (!rst_n) begin
      regs.mode  = MODE_MATRIX;
      regs.row_x = ROW_X_RST;
      regs.row_y = ROW_Y_RST;
      regs.off_x = '0;
      regs.off_y = '0;
      regs.lam   = LAM_RST;
      expected_beams.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   regs.mode  = xform_mode_t'(cfg_data[0]);
          REG_ROW_X:  regs.row_x = cfg_data[ROW_W-1:0];
          REG_ROW_Y:  regs.row_y = cfg_data[ROW_W-1:0];
          REG_OFF_X:  regs.off_x = cfg_data[DATA_WIDTH-1:0];
          REG_OFF_Y:  regs.off_y = cfg_data[DATA_WIDTH-1:0];
          REG_LAMBDA: regs.lam   = cfg_data[LAM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (remap_frequency(in_x, in_y, in_z, predicted)) expected_beams.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        seen.fx = out_x;
        seen.fy = out_y;
        seen.kz = out_z;
        if (expected_beams.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result word x=%0d y=%0d z=%0d",
                     $time, seen.fx, seen.fy, seen.kz);
        end else begin
          oldest = expected_beams.pop_front();
          if (seen.fx !== oldest.fx || seen.fy !== oldest.fy || seen.kz !== oldest.kz) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch, expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       $time, oldest.fx, oldest.fy, oldest.kz, seen.fx, seen.fy, seen.kz);
          end
        end
      end
    end
    beams_pending = expected_beams.size();
  end

endmodule

### tb/spectral_frequency_remap_unit_tb.sv
// Stimulus and verdict for the spectral frequency remap unit: register settings, directed
// and random frequency words, random input gaps and result stalls. Depends on sfr_pkg,
// the block and spectral_remap_checker.
`timescale 1ns / 1ps

module spectral_frequency_remap_unit_tb import sfr_pkg::*;;

  localparam int PIPE_DEPTH      = 16;
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 135;
  localparam int PRESSURE_PHASE  = 3;
  localparam int DARK_PHASE      = 5;
  localparam int HOLD_CYCLES     = 300;

  localparam logic [CFG_IDX_W-1:0]         REG_SPARE = 3'd6;
  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]     COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]     COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]     COEF_HALF = COEF_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [LAM_W-1:0]             LAM_MAX   = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [DATA_WIDTH-1:0] in_x, in_y, in_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_x, out_y;
  logic [DATA_WIDTH-1:0] out_z;

  int   mismatch_count;
  int   beams_pending;
  int   gap_odds = 0;
  logic hold_go = 1'b0;
  logic quiet = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;
  int   burst_left = 0;

  always #5 clk = ~clk;

  spectral_frequency_remap_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  spectral_remap_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .mismatch_count (mismatch_count),
    .beams_pending  (beams_pending)
  );

  // Result side: one long hold-off on request, otherwise random stall bursts.
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rst_n && !quiet && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [ROW_W-1:0] pack_row(input logic signed [COEF_W-1:0] cx,
                                                input logic signed [COEF_W-1:0] cy,
                                                input logic signed [COEF_W-1:0] cz);
    return {cz, cy, cx};
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] rand_field();
    logic signed [DATA_WIDTH-1:0] v;
    v = DATA_WIDTH'($urandom);
    case ($urandom_range(0, 15))
      0:       v = DATA_MAX;
      1:       v = DATA_MIN;
      default: v = v >>> $urandom_range(0, DATA_WIDTH - 1);
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    case ($urandom_range(0, 15))
      0:       c = COEF_MAX;
      1:       c = COEF_MIN;
      default: c = c >>> $urandom_range(0, COEF_W - 1);
    endcase
    return c;
  endfunction

  // Fill the bits above the register width with junk; the block must ignore them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CFG_DATA_W'(junk) << width) | value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input xform_mode_t mode, input logic [ROW_W-1:0] row_x,
                              input logic [ROW_W-1:0] row_y,
                              input logic signed [DATA_WIDTH-1:0] off_x,
                              input logic signed [DATA_WIDTH-1:0] off_y,
                              input logic [LAM_W-1:0] lam);
    write_reg(REG_MODE, mode, 1);
    write_reg(REG_ROW_X, row_x, ROW_W);
    write_reg(REG_ROW_Y, row_y, ROW_W);
    write_reg(REG_OFF_X, off_x, DATA_WIDTH);
    write_reg(REG_OFF_Y, off_y, DATA_WIDTH);
    write_reg(REG_LAMBDA, lam, LAM_W);
    write_reg(REG_SPARE, '0, 0);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic signed [DATA_WIDTH-1:0] x,
                           input logic signed [DATA_WIDTH-1:0] y,
                           input logic signed [DATA_WIDTH-1:0] z);
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Drop valid, drain every expected word, then let dropped words clear the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (beams_pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  initial begin
    logic [LAM_W-1:0] lam;
    logic [63:0]      lam_bits;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_x      = '0;
    in_y      = '0;
    in_z      = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: identity rows, 1/lambda^2 = 1.0; hit the boundary of the unit circle.
    gap_odds = 4;
    send_word(0, 0, 0);
    send_word(24'sd4096, 0, DATA_MIN);
    send_word(0, -24'sd4096, DATA_MAX);
    send_word(24'sd4097, 0, 0);
    send_word(24'sd2048, -24'sd2048, 24'sd77);
    send_word(-24'sd1, 24'sd1, 0);
    settle();

    // Extreme coefficients and inputs: matrix sums saturate both ways.
    program_regs(MODE_MATRIX, pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                 pack_row(COEF_MIN, COEF_MIN, COEF_MIN), 0, 0, LAM_MAX);
    for (int c = 0; c < 8; c++)
      send_word(c[0] ? DATA_MIN : DATA_MAX, c[1] ? DATA_MIN : DATA_MAX,
                c[2] ? DATA_MIN : DATA_MAX);
    settle();

    // Offset subtract with extreme offsets; z is ignored.
    program_regs(MODE_SHIFT, pack_row(COEF_MIN, 0, COEF_MAX), pack_row(0, COEF_MAX, 0),
                 DATA_MAX, DATA_MIN, LAM_MAX);
    send_word(DATA_MIN, DATA_MAX, 24'sd5);
    send_word(DATA_MAX, DATA_MIN, DATA_MIN);
    send_word(0, 0, DATA_MAX);
    settle();

    // Half coefficients: halfway values round up, negative ones toward zero.
    program_regs(MODE_MATRIX, pack_row(COEF_HALF, 0, 0), pack_row(0, 0, -COEF_HALF),
                 DATA_MIN, DATA_MAX, LAM_MAX);
    send_word(24'sd1, 0, 24'sd1);
    send_word(-24'sd1, 0, -24'sd1);
    send_word(24'sd3, 0, 24'sd3);
    send_word(-24'sd3, 0, -24'sd3);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      lam_bits = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       lam = LAM_MAX;
        1:       lam = LAM_RST;
        default: lam = LAM_W'(lam_bits >> $urandom_range(16, 62));
      endcase
      if (p == PRESSURE_PHASE) lam = LAM_MAX;
      if (p == DARK_PHASE) lam = '0;
      program_regs(xform_mode_t'(p[0]), pack_row(rand_coef(), rand_coef(), rand_coef()),
                   pack_row(rand_coef(), rand_coef(), rand_coef()), rand_field(),
                   rand_field(), lam);
      gap_odds = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
      if (p == PRESSURE_PHASE) begin
        gap_odds = 0;
        hold_go <= 1'b1;
      end
      if (p == RAND_PHASES - 1) begin
        gap_odds = 0;
        quiet <= 1'b1;
      end
      repeat (WORDS_PER_PHASE) send_word(rand_field(), rand_field(), rand_field());
      settle();
    end

    if (mismatch_count == 0 && beams_pending == 0) begin
      $display("spectral_frequency_remap_unit verification clean");
    end else begin
      $display("spectral_frequency_remap_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("spectral_frequency_remap_unit verification failed");
    $finish;
  end

endmodule
